// ===== rtl/tsg_pkg.sv =====
// ----------------------------------------------------------------------------
// tsg_pkg
// Shared widths, codes and sequencer states of the three-axis step generator.
// ----------------------------------------------------------------------------
package tsg_pkg;

  // axis distances and feed rates
  localparam int DIST_W     = 21;
  localparam int RATE_W     = 20;
  localparam int NUM_AXES   = 3;
  localparam int AXIS_IDX_W = 2;

  // time base
  localparam int TICKS_PER_SECOND = 1000000;
  localparam int TPS_W            = 20;
  localparam int TIME_W           = 41;

  // shared multiplier product, divider dividend, error accumulator
  localparam int PROD_W     = DIST_W + RATE_W;
  localparam int DIVD_W     = PROD_W + 1;
  localparam int DIV_CNT_W  = $clog2(DIVD_W + 1);
  localparam int ACC_W      = TIME_W + DIST_W + 2;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_Z = 2'd2;
  localparam logic [RATE_W-1:0]    RATE_RESET = 20'd1000;

  // input command codes
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_START = 1'b1;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CMP_A,
    ST_CMP_B,
    ST_CMP_C,
    ST_DUR_MUL,
    ST_DUR_DIV,
    ST_DUR_WAIT,
    ST_TICK,
    ST_ACC,
    ST_STEP,
    ST_FIN,
    ST_OUT
  } state_t;

endpackage

// ===== rtl/tsg_mul.sv =====
// ----------------------------------------------------------------------------
// tsg_mul
// Shared registered multiplier, distance by rate, product in the next cycle.
// ----------------------------------------------------------------------------
module tsg_mul (
  input  logic                         clk,
  input  logic [tsg_pkg::DIST_W-1:0]   op_a,
  input  logic [tsg_pkg::RATE_W-1:0]   op_b,
  output logic [tsg_pkg::PROD_W-1:0]   prod_r
);

  // product register
  always_ff @(posedge clk) begin
    prod_r <= tsg_pkg::PROD_W'(op_a) * tsg_pkg::PROD_W'(op_b);
  end

endmodule

// ===== rtl/tsg_div.sv =====
// ----------------------------------------------------------------------------
// tsg_div
// Restoring divider, one quotient bit per cycle, done pulse at the end.
// ----------------------------------------------------------------------------
module tsg_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [tsg_pkg::DIVD_W-1:0]    dividend,
  input  logic [tsg_pkg::RATE_W-1:0]    divisor,
  output logic                          done,
  output logic [tsg_pkg::DIVD_W-1:0]    quotient
);

  logic                            busy_r;
  logic                            done_r;
  logic [tsg_pkg::DIV_CNT_W-1:0]   cnt_r;
  logic [tsg_pkg::DIVD_W-1:0]      quo_r;
  logic [tsg_pkg::RATE_W-1:0]      rem_r;
  logic [tsg_pkg::RATE_W-1:0]      dsr_r;

  logic [tsg_pkg::RATE_W:0]        rem_sh;
  logic [tsg_pkg::RATE_W:0]        rem_diff;
  logic                            rem_ge;

  // trial subtract of the divisor from the shifted remainder
  always_comb begin
    rem_sh   = {rem_r, quo_r[tsg_pkg::DIVD_W-1]};
    rem_ge   = rem_sh >= {1'b0, dsr_r};
    rem_diff = rem_sh - {1'b0, dsr_r};
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= tsg_pkg::DIV_CNT_W'(tsg_pkg::DIVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - tsg_pkg::DIV_CNT_W'(1);
        if (cnt_r == tsg_pkg::DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out as quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[tsg_pkg::DIVD_W-2:0], rem_ge};
      rem_r <= rem_ge ? rem_diff[tsg_pkg::RATE_W-1:0] : rem_sh[tsg_pkg::RATE_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== rtl/timed_three_axis_step_generator.sv =====
// Start transaction: the result follows the serial divider that works out the
// move time; refused starts go straight to the output state. Tick while moving:
// one shared 64-bit adder visited twice per axis. Tick while idle goes straight
// to the output state. One transaction at a time; in_ready is high again as the
// result is loaded into the output register.
// Synchronous active-low reset: idle, no move, rates back to 1000 steps/s.
// ----------------------------------------------------------------------------
// timed_three_axis_step_generator
// Three-axis linear move step generator with timed interpolation, driven by
// a small sequencer around a shared multiplier, divider and adder.
// ----------------------------------------------------------------------------
module timed_three_axis_step_generator (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // configuration
  input  logic                                   cfg_we,
  input  logic [tsg_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [tsg_pkg::RATE_W-1:0]             cfg_wdata,
  // input channel
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_command,
  input  logic signed [tsg_pkg::DIST_W-1:0]      in_delta_x,
  input  logic signed [tsg_pkg::DIST_W-1:0]      in_delta_y,
  input  logic signed [tsg_pkg::DIST_W-1:0]      in_delta_z,
  // result channel
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   out_step_x,
  output logic                                   out_step_y,
  output logic                                   out_step_z,
  output logic                                   out_dir_x,
  output logic                                   out_dir_y,
  output logic                                   out_dir_z,
  output logic                                   out_busy_res,
  output logic                                   out_move_done,
  output logic                                   out_start_refused
);

  localparam int NA = tsg_pkg::NUM_AXES;

  tsg_pkg::state_t                          state_r, state_nxt;
  logic [tsg_pkg::AXIS_IDX_W-1:0]           idx_r;

  logic [tsg_pkg::RATE_W-1:0]               rate_r   [NA];
  logic [tsg_pkg::RATE_W-1:0]               eff_rate [NA];
  logic [tsg_pkg::DIST_W-1:0]               delta_r  [NA];
  logic [tsg_pkg::DIST_W-1:0]               mag      [NA];
  logic                                     dir_in   [NA];

  logic [tsg_pkg::DIST_W-1:0]               dist_r   [NA];
  logic [tsg_pkg::DIST_W-1:0]               steps_r  [NA];
  logic signed [tsg_pkg::ACC_W-1:0]         acc_r    [NA];
  logic                                     dir_r    [NA];
  logic [tsg_pkg::TIME_W-1:0]               dur_r;
  logic [tsg_pkg::TIME_W-1:0]               elapsed_r;
  logic                                     inc_r;
  logic                                     moving_r;

  logic [tsg_pkg::DIST_W-1:0]               ld_r;
  logic [tsg_pkg::RATE_W-1:0]               lr_r;
  logic [tsg_pkg::PROD_W-1:0]               pa_r;

  logic [NA-1:0]                            res_step_r;
  logic                                     res_done_r;
  logic                                     res_refused_r;

  logic                                     out_valid_r;
  logic [NA-1:0]                            out_step_r;
  logic [NA-1:0]                            out_dir_r;
  logic                                     out_busy_r;
  logic                                     out_done_r;
  logic                                     out_refused_r;

  logic [tsg_pkg::DIST_W-1:0]               mul_a;
  logic [tsg_pkg::RATE_W-1:0]               mul_b;
  logic [tsg_pkg::PROD_W-1:0]               mul_prod;
  logic                                     div_start;
  logic                                     div_done;
  logic [tsg_pkg::DIVD_W-1:0]               div_dividend;
  logic [tsg_pkg::DIVD_W-1:0]               div_quot;

  logic signed [tsg_pkg::ACC_W-1:0]         add_b;
  logic signed [tsg_pkg::ACC_W-1:0]         add_sum;
  logic                                     step_fire;
  logic                                     all_done;
  logic                                     any_dist;
  logic                                     out_free;
  logic                                     in_take;

  // effective rates, input magnitudes and direction bits
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      eff_rate[i] = (rate_r[i] == '0) ? tsg_pkg::RATE_W'(1) : rate_r[i];
      mag[i]      = delta_r[i][tsg_pkg::DIST_W-1] ? (~delta_r[i] + tsg_pkg::DIST_W'(1))
                                                  : delta_r[i];
      dir_in[i]   = !delta_r[i][tsg_pkg::DIST_W-1] && (delta_r[i] != '0);
    end
  end

  // move summary flags
  always_comb begin
    all_done = 1'b1;
    any_dist = 1'b0;
    for (int i = 0; i < NA; i++) begin
      if (steps_r[i] != dist_r[i]) all_done = 1'b0;
      if (dist_r[i] != '0)         any_dist = 1'b1;
    end
  end

  // shared adder: add distance on a tick that advances the elapsed count, subtract move time on a step
  always_comb begin
    if (state_r == tsg_pkg::ST_ACC) begin
      add_b = inc_r ? $signed(tsg_pkg::ACC_W'(dist_r[idx_r])) : '0;
    end else begin
      add_b = -$signed(tsg_pkg::ACC_W'(dur_r));
    end
    add_sum   = acc_r[idx_r] + add_b;
    step_fire = (steps_r[idx_r] != dist_r[idx_r]) &&
                !acc_r[idx_r][tsg_pkg::ACC_W-1] && (acc_r[idx_r] != '0);
  end

  assign div_dividend = tsg_pkg::DIVD_W'(mul_prod) + tsg_pkg::DIVD_W'(lr_r)
                        - tsg_pkg::DIVD_W'(1);
  assign out_free     = !out_valid_r || out_ready;
  assign in_take      = in_valid && in_ready;

  // shared units
  tsg_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (mul_prod)
  );

  tsg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (lr_r),
    .done     (div_done),
    .quotient (div_quot)
  );

  // sequencer state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tsg_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // sequencer next state and unit controls
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    unique case (state_r)
      tsg_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_command == tsg_pkg::CMD_START) begin
            state_nxt = moving_r ? tsg_pkg::ST_OUT : tsg_pkg::ST_LOAD;
          end else begin
            state_nxt = moving_r ? tsg_pkg::ST_TICK : tsg_pkg::ST_OUT;
          end
        end
      end
      tsg_pkg::ST_LOAD: begin
        state_nxt = tsg_pkg::ST_CMP_A;
      end
      tsg_pkg::ST_CMP_A: begin
        mul_a     = ld_r;
        mul_b     = eff_rate[idx_r];
        state_nxt = tsg_pkg::ST_CMP_B;
      end
      tsg_pkg::ST_CMP_B: begin
        mul_a     = dist_r[idx_r];
        mul_b     = lr_r;
        state_nxt = tsg_pkg::ST_CMP_C;
      end
      tsg_pkg::ST_CMP_C: begin
        state_nxt = (idx_r == tsg_pkg::AXIS_IDX_W'(NA - 1)) ? tsg_pkg::ST_DUR_MUL
                                                             : tsg_pkg::ST_CMP_A;
      end
      tsg_pkg::ST_DUR_MUL: begin
        mul_a     = ld_r;
        mul_b     = tsg_pkg::TPS_W'(tsg_pkg::TICKS_PER_SECOND);
        state_nxt = tsg_pkg::ST_DUR_DIV;
      end
      tsg_pkg::ST_DUR_DIV: begin
        div_start = 1'b1;
        state_nxt = tsg_pkg::ST_DUR_WAIT;
      end
      tsg_pkg::ST_DUR_WAIT: begin
        if (div_done) state_nxt = tsg_pkg::ST_OUT;
      end
      tsg_pkg::ST_TICK: begin
        state_nxt = tsg_pkg::ST_ACC;
      end
      tsg_pkg::ST_ACC: begin
        state_nxt = tsg_pkg::ST_STEP;
      end
      tsg_pkg::ST_STEP: begin
        state_nxt = (idx_r == tsg_pkg::AXIS_IDX_W'(NA - 1)) ? tsg_pkg::ST_FIN
                                                             : tsg_pkg::ST_ACC;
      end
      tsg_pkg::ST_FIN: begin
        state_nxt = tsg_pkg::ST_OUT;
      end
      tsg_pkg::ST_OUT: begin
        if (out_free) state_nxt = tsg_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = tsg_pkg::ST_IDLE;
      end
    endcase
  end

  // feed rate registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NA; i++) rate_r[i] <= tsg_pkg::RATE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tsg_pkg::REG_RATE_X: rate_r[0] <= cfg_wdata;
        tsg_pkg::REG_RATE_Y: rate_r[1] <= cfg_wdata;
        tsg_pkg::REG_RATE_Z: rate_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // transaction capture
  always_ff @(posedge clk) begin
    if (in_take) begin
      delta_r[0] <= in_delta_x;
      delta_r[1] <= in_delta_y;
      delta_r[2] <= in_delta_z;
    end
  end

  // move state: distances, steps, error terms, timing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NA; i++) begin
        dist_r[i]  <= '0;
        steps_r[i] <= '0;
        acc_r[i]   <= '0;
        dir_r[i]   <= 1'b0;
      end
      dur_r         <= '0;
      elapsed_r     <= '0;
      inc_r         <= 1'b0;
      moving_r      <= 1'b0;
      idx_r         <= '0;
      res_step_r    <= '0;
      res_done_r    <= 1'b0;
      res_refused_r <= 1'b0;
    end else begin
      unique case (state_r)
        tsg_pkg::ST_IDLE: begin
          if (in_take) begin
            res_step_r    <= '0;
            res_done_r    <= 1'b0;
            res_refused_r <= (in_command == tsg_pkg::CMD_START) && moving_r;
          end
        end
        // latch the new move and seed the longest-axis search with X
        tsg_pkg::ST_LOAD: begin
          for (int i = 0; i < NA; i++) begin
            dist_r[i]  <= mag[i];
            dir_r[i]   <= dir_in[i];
            steps_r[i] <= '0;
            acc_r[i]   <= '0;
          end
          elapsed_r <= '0;
          idx_r     <= tsg_pkg::AXIS_IDX_W'(1);
        end
        tsg_pkg::ST_CMP_C: begin
          idx_r <= idx_r + tsg_pkg::AXIS_IDX_W'(1);
        end
        // move complete at once when every distance is zero
        tsg_pkg::ST_DUR_WAIT: begin
          if (div_done) begin
            dur_r      <= (|div_quot[tsg_pkg::DIVD_W-1:tsg_pkg::TIME_W]) ? '1
                          : div_quot[tsg_pkg::TIME_W-1:0];
            moving_r   <= any_dist;
            res_done_r <= !any_dist;
          end
        end
        // elapsed count stops at the move time
        tsg_pkg::ST_TICK: begin
          inc_r <= elapsed_r < dur_r;
          if (elapsed_r < dur_r) elapsed_r <= elapsed_r + tsg_pkg::TIME_W'(1);
          idx_r <= '0;
        end
        tsg_pkg::ST_ACC: begin
          acc_r[idx_r] <= add_sum;
        end
        tsg_pkg::ST_STEP: begin
          if (step_fire) begin
            acc_r[idx_r]      <= add_sum;
            steps_r[idx_r]    <= steps_r[idx_r] + tsg_pkg::DIST_W'(1);
            res_step_r[idx_r] <= 1'b1;
          end
          idx_r <= idx_r + tsg_pkg::AXIS_IDX_W'(1);
        end
        tsg_pkg::ST_FIN: begin
          if (all_done) begin
            moving_r   <= 1'b0;
            res_done_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // longest-axis search: pa_r = ld * rate_i, compared against dist_i * lr
  always_ff @(posedge clk) begin
    if (state_r == tsg_pkg::ST_LOAD) begin
      ld_r <= mag[0];
      lr_r <= eff_rate[0];
    end else if (state_r == tsg_pkg::ST_CMP_C && pa_r < mul_prod) begin
      ld_r <= dist_r[idx_r];
      lr_r <= eff_rate[idx_r];
    end
    if (state_r == tsg_pkg::ST_CMP_B) pa_r <= mul_prod;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == tsg_pkg::ST_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == tsg_pkg::ST_OUT && out_free) begin
      out_step_r    <= res_step_r;
      out_dir_r     <= {dir_r[2], dir_r[1], dir_r[0]};
      out_busy_r    <= moving_r;
      out_done_r    <= res_done_r;
      out_refused_r <= res_refused_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_step_x        = out_step_r[0];
  assign out_step_y        = out_step_r[1];
  assign out_step_z        = out_step_r[2];
  assign out_dir_x         = out_dir_r[0];
  assign out_dir_y         = out_dir_r[1];
  assign out_dir_z         = out_dir_r[2];
  assign out_busy_res      = out_busy_r;
  assign out_move_done     = out_done_r;
  assign out_start_refused = out_refused_r;

`ifndef SYNTHESIS
  // no axis ever steps past its distance
  a_steps_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (steps_r[0] <= dist_r[0]) && (steps_r[1] <= dist_r[1]) && (steps_r[2] <= dist_r[2]))
    else $error("axis step count exceeds its distance");

  // elapsed count never passes the move time between transactions
  a_elapsed_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tsg_pkg::ST_IDLE) |-> (elapsed_r <= dur_r))
    else $error("elapsed count beyond move time");

  // a finished move is never reported as still busy
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_done_r) |-> !out_busy_r)
    else $error("move done while still busy");

  // a refused start only happens during a running move
  a_refused_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_refused_r) |-> (out_busy_r && (out_step_r == '0)))
    else $error("refused start outside a move");
`endif

endmodule

// ===== bench/timed_three_axis_step_generator_tb.sv =====
// ----------------------------------------------------------------------------
// timed_three_axis_step_generator_tb
// Self-checking bench for the three-axis step generator. A bit-exact motion
// predictor follows every accepted transaction and queues the step, direction
// and status bits it expects; a monitor checks each result transaction
// against the oldest entry. Directed moves cover idle ticks, reset rates,
// rate extremes and refused starts. Random moves with bounded durations then
// run under four handshake idling mixes.
// ----------------------------------------------------------------------------
module timed_three_axis_step_generator_tb;

  localparam int CYCLE_LIMIT       = 1000000;
  localparam int DRAIN_CYCLES      = 64;
  localparam int ITEMS_PER_SETTING = 194;
  localparam logic [tsg_pkg::RATE_W-1:0] RATE_MAX = '1;
  localparam logic [63:0] TIME_MAX = (64'd1 << tsg_pkg::TIME_W) - 64'd1;
  localparam logic [63:0] DIST_MAX = (64'd1 << tsg_pkg::DIST_W) - 64'd1;
  localparam logic signed [tsg_pkg::DIST_W-1:0] DELTA_MIN =
    {1'b1, {(tsg_pkg::DIST_W-1){1'b0}}};
  localparam logic signed [tsg_pkg::DIST_W-1:0] DELTA_MAX =
    {1'b0, {(tsg_pkg::DIST_W-1){1'b1}}};

  // one result transaction
  typedef struct packed {
    logic step_x;
    logic step_y;
    logic step_z;
    logic dir_x;
    logic dir_y;
    logic dir_z;
    logic busy_res;
    logic move_done;
    logic start_refused;
  } motion_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [tsg_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [tsg_pkg::RATE_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_command = tsg_pkg::CMD_TICK;
  logic signed [tsg_pkg::DIST_W-1:0] in_delta_x = '0;
  logic signed [tsg_pkg::DIST_W-1:0] in_delta_y = '0;
  logic signed [tsg_pkg::DIST_W-1:0] in_delta_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_step_x, out_step_y, out_step_z;
  logic out_dir_x, out_dir_y, out_dir_z;
  logic out_busy_res, out_move_done, out_start_refused;

  // predictor state
  logic [tsg_pkg::RATE_W-1:0] rate_q [3] =
    '{tsg_pkg::RATE_RESET, tsg_pkg::RATE_RESET, tsg_pkg::RATE_RESET};
  logic [2:0] dir_q = '0;
  logic [tsg_pkg::DIST_W-1:0] dist_q [3] = '{'0, '0, '0};
  logic [tsg_pkg::DIST_W-1:0] taken_q [3] = '{'0, '0, '0};
  logic [tsg_pkg::TIME_W-1:0] dur_q = '0;
  logic [tsg_pkg::TIME_W-1:0] elapsed_q = '0;
  logic moving_q = 1'b0;

  motion_result_t pending_motion_q [$];
  motion_result_t head_motion;
  int error_count = 0;
  int motion_items = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int axis_span [3] = '{0, 0, 0};
  int unsigned cycle_count = 0;

  timed_three_axis_step_generator uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_delta_x        (in_delta_x),
    .in_delta_y        (in_delta_y),
    .in_delta_z        (in_delta_z),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_step_x        (out_step_x),
    .out_step_y        (out_step_y),
    .out_step_z        (out_step_z),
    .out_dir_x         (out_dir_x),
    .out_dir_y         (out_dir_y),
    .out_dir_z         (out_dir_z),
    .out_busy_res      (out_busy_res),
    .out_move_done     (out_move_done),
    .out_start_refused (out_start_refused)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // motion predictor: advances its state by one transaction
  function automatic motion_result_t predict_motion(
      input logic cmd,
      input logic signed [tsg_pkg::DIST_W-1:0] dx,
      input logic signed [tsg_pkg::DIST_W-1:0] dy,
      input logic signed [tsg_pkg::DIST_W-1:0] dz);
    motion_result_t res;
    logic [tsg_pkg::DIST_W-1:0] raw [3];
    logic [63:0] eff [3];
    logic [63:0] mag, ld, lr, dur;
    logic [127:0] ahead, behind;
    logic [2:0] stepped;
    int i;
    res = '0;
    stepped = '0;
    raw[0] = dx;
    raw[1] = dy;
    raw[2] = dz;
    if (cmd == tsg_pkg::CMD_START) begin
      if (moving_q) begin
        res.start_refused = 1'b1;
      end else begin
        // latch direction and magnitude, zero rate counts as one
        for (i = 0; i < 3; i++) begin
          eff[i] = (rate_q[i] == '0) ? 64'd1 : 64'(rate_q[i]);
          if (raw[i][tsg_pkg::DIST_W-1]) begin
            mag = (64'd1 << tsg_pkg::DIST_W) - 64'(raw[i]);
            dir_q[i] = 1'b0;
          end else begin
            mag = 64'(raw[i]);
            dir_q[i] = (raw[i] != '0);
          end
          if (mag > DIST_MAX) mag = DIST_MAX;
          dist_q[i] = mag[tsg_pkg::DIST_W-1:0];
          taken_q[i] = '0;
        end
        // longest axis by cross-multiplied compare, earlier axis wins ties
        ld = 64'(dist_q[0]);
        lr = eff[0];
        for (i = 1; i < 3; i++) begin
          if (ld * eff[i] < 64'(dist_q[i]) * lr) begin
            ld = 64'(dist_q[i]);
            lr = eff[i];
          end
        end
        // exact ceiling of the move time
        dur = (ld * 64'(tsg_pkg::TICKS_PER_SECOND) + lr - 64'd1) / lr;
        if (dur > TIME_MAX) dur = TIME_MAX;
        dur_q = dur[tsg_pkg::TIME_W-1:0];
        elapsed_q = '0;
        moving_q = (dist_q[0] | dist_q[1] | dist_q[2]) != '0;
        res.move_done = !moving_q;
      end
    end else if (moving_q) begin
      // elapsed count holds at the move time
      if (elapsed_q < dur_q) elapsed_q = elapsed_q + 1'b1;
      for (i = 0; i < 3; i++) begin
        ahead = 128'(elapsed_q) * 128'(dist_q[i]);
        behind = 128'(taken_q[i]) * 128'(dur_q);
        if (taken_q[i] != dist_q[i] && ahead > behind) begin
          taken_q[i] = taken_q[i] + 1'b1;
          stepped[i] = 1'b1;
        end
      end
      if (taken_q[0] == dist_q[0] && taken_q[1] == dist_q[1] && taken_q[2] == dist_q[2]) begin
        moving_q = 1'b0;
        res.move_done = 1'b1;
      end
    end
    res.step_x = stepped[0];
    res.step_y = stepped[1];
    res.step_z = stepped[2];
    res.dir_x = dir_q[0];
    res.dir_y = dir_q[1];
    res.dir_z = dir_q[2];
    res.busy_res = moving_q;
    return res;
  endfunction

  function automatic logic signed [tsg_pkg::DIST_W-1:0] random_raw();
    return tsg_pkg::DIST_W'($urandom());
  endfunction

  // signed delta with magnitude up to span
  function automatic logic signed [tsg_pkg::DIST_W-1:0] random_delta(input int span);
    int mag;
    mag = $urandom_range(span, 0);
    return ($urandom_range(1, 0) == 1) ? tsg_pkg::DIST_W'(-mag) : tsg_pkg::DIST_W'(mag);
  endfunction

  function automatic void check_field(input string field, input logic expected_bit,
                                      input logic actual_bit);
    if (actual_bit !== expected_bit) begin
      error_count++;
      $display("%0t: %s mismatch, expected %b actual %b", $time, field, expected_bit,
               actual_bit);
    end
  endfunction

  // send one transaction, record its prediction when accepted
  task automatic send_motion(input logic cmd,
                             input logic signed [tsg_pkg::DIST_W-1:0] dx,
                             input logic signed [tsg_pkg::DIST_W-1:0] dy,
                             input logic signed [tsg_pkg::DIST_W-1:0] dz);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_delta_x <= dx;
    in_delta_y <= dy;
    in_delta_z <= dz;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (!(cmd == tsg_pkg::CMD_TICK && !moving_q)) motion_items++;
    pending_motion_q.push_back(predict_motion(cmd, dx, dy, dz));
  endtask

  task automatic send_tick();
    send_motion(tsg_pkg::CMD_TICK, random_raw(), random_raw(), random_raw());
  endtask

  // tick until the move is over, with some refused starts mixed in
  task automatic finish_move(input int refuse_pct);
    while (moving_q) begin
      if ($urandom_range(99, 0) < refuse_pct)
        send_motion(tsg_pkg::CMD_START, random_raw(), random_raw(), random_raw());
      else
        send_tick();
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_motion_q.size() != 0) @(posedge clk);
  endtask

  // rate writes, only with nothing in flight
  task automatic set_rates(input logic [tsg_pkg::RATE_W-1:0] rx,
                           input logic [tsg_pkg::RATE_W-1:0] ry,
                           input logic [tsg_pkg::RATE_W-1:0] rz);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= tsg_pkg::REG_RATE_X;
    cfg_wdata <= rx;
    rate_q[0] = rx;
    @(posedge clk);
    cfg_index <= tsg_pkg::REG_RATE_Y;
    cfg_wdata <= ry;
    rate_q[1] = ry;
    @(posedge clk);
    cfg_index <= tsg_pkg::REG_RATE_Z;
    cfg_wdata <= rz;
    rate_q[2] = rz;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // ticks with no move running, field extremes on the ignored deltas
  task automatic test_idle_ticks();
    send_motion(tsg_pkg::CMD_TICK, DELTA_MAX, DELTA_MAX, DELTA_MAX);
    send_motion(tsg_pkg::CMD_TICK, DELTA_MIN, DELTA_MIN, DELTA_MIN);
    send_motion(tsg_pkg::CMD_TICK, '0, '0, '0);
  endtask

  // moves under the rates left by reset, ties between axes
  task automatic test_reset_rates();
    send_motion(tsg_pkg::CMD_START, 1, -1, 0);
    finish_move(0);
    send_motion(tsg_pkg::CMD_START, -1, 0, 1);
    finish_move(0);
  endtask

  // zero, one and full-scale rates, empty moves, saturated elapsed count
  task automatic test_rate_extremes();
    set_rates(RATE_MAX, RATE_MAX, RATE_MAX);
    send_motion(tsg_pkg::CMD_START, 0, 0, 0);
    send_motion(tsg_pkg::CMD_START, 3, 3, 3);
    finish_move(0);
    send_motion(tsg_pkg::CMD_START, -40, 21, -7);
    finish_move(0);
    set_rates('0, RATE_MAX, tsg_pkg::RATE_W'(1));
    send_motion(tsg_pkg::CMD_START, 0, 0, 0);
    send_motion(tsg_pkg::CMD_START, 0, -9, 0);
    finish_move(0);
    send_motion(tsg_pkg::CMD_START, 0, 0, 1);
    finish_move(0);
    set_rates(RATE_MAX, tsg_pkg::RATE_W'(524288), RATE_MAX);
    send_motion(tsg_pkg::CMD_START, 4, -2, 0);
    finish_move(0);
    set_rates(tsg_pkg::RATE_W'(16384), RATE_MAX, '0);
    send_motion(tsg_pkg::CMD_START, 1, 60, 0);
    finish_move(0);
    set_rates(tsg_pkg::RATE_W'(1), RATE_MAX, '0);
    send_motion(tsg_pkg::CMD_START, 1, 0, -1);
    finish_move(0);
  endtask

  // starts that arrive while a move runs
  task automatic test_refused_starts();
    set_rates(RATE_MAX, RATE_MAX, RATE_MAX);
    send_motion(tsg_pkg::CMD_START, 10, -10, 5);
    send_motion(tsg_pkg::CMD_START, DELTA_MIN, DELTA_MIN, DELTA_MIN);
    send_motion(tsg_pkg::CMD_START, DELTA_MAX, DELTA_MAX, DELTA_MAX);
    send_motion(tsg_pkg::CMD_START, 0, 0, 0);
    finish_move(0);
  endtask

  // random moves under four idling mixes, fresh rates twice per mix
  task automatic test_random_moves();
    int send_pct [4];
    int stall_pct [4];
    logic [tsg_pkg::RATE_W-1:0] picked [3];
    int phase, setting, i, first, roll;
    send_pct = '{0, 56, 0, 6};
    stall_pct = '{0, 0, 56, 6};
    for (phase = 0; phase < 4; phase++) begin
      send_idle_pct = send_pct[phase];
      recv_stall_pct = stall_pct[phase];
      for (setting = 0; setting < 2; setting++) begin
        // span keeps every move within about sixty ticks
        for (i = 0; i < 3; i++) begin
          if ($urandom_range(9, 0) == 0) begin
            picked[i] = '0;
            axis_span[i] = 0;
          end else begin
            picked[i] = tsg_pkg::RATE_W'($urandom_range(RATE_MAX, 16384));
            axis_span[i] = int'(picked[i] >> 14);
          end
        end
        set_rates(picked[0], picked[1], picked[2]);
        first = motion_items;
        while (motion_items - first < ITEMS_PER_SETTING) begin
          roll = $urandom_range(99, 0);
          if (roll < 85) begin
            send_motion(tsg_pkg::CMD_START, random_delta(axis_span[0]),
                        random_delta(axis_span[1]), random_delta(axis_span[2]));
            finish_move(3);
          end else if (roll < 93) begin
            send_tick();
          end else begin
            send_motion(tsg_pkg::CMD_START, '0, '0, '0);
          end
        end
      end
    end
  endtask

  // result monitor and receiver stalls
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_motion_q.size() == 0) begin
        error_count++;
        $display("%0t: result transaction with none pending, expected none actual %b",
                 $time, {out_step_x, out_step_y, out_step_z, out_dir_x, out_dir_y,
                 out_dir_z, out_busy_res, out_move_done, out_start_refused});
      end else begin
        head_motion = pending_motion_q.pop_front();
        check_field("step_x", head_motion.step_x, out_step_x);
        check_field("step_y", head_motion.step_y, out_step_y);
        check_field("step_z", head_motion.step_z, out_step_z);
        check_field("dir_x", head_motion.dir_x, out_dir_x);
        check_field("dir_y", head_motion.dir_y, out_dir_y);
        check_field("dir_z", head_motion.dir_z, out_dir_z);
        check_field("busy_res", head_motion.busy_res, out_busy_res);
        check_field("move_done", head_motion.move_done, out_move_done);
        check_field("start_refused", head_motion.start_refused, out_start_refused);
      end
    end
    out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  // test sequence
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_ticks();
    test_reset_rates();
    test_rate_extremes();
    test_refused_starts();
    test_random_moves();
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_motion_q.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
